@@ design/lcg_bus_pkg.sv @@
// package for the lcg binomial/uniform sampler
// holds action codes, sizing constants and the small mod-3 helper
// no dependencies
package lcg_bus_pkg;

    // action codes carried by the input item
    typedef enum logic [2:0] {
        ACT_RESEED   = 3'd0,
        ACT_UNIFORM  = 3'd1,
        ACT_BINOMIAL = 3'd2,
        ACT_BOUNDED  = 3'd3,
        ACT_RESTART  = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic {
        CFG_MULTIPLIER = 1'b0,
        CFG_INCREMENT  = 1'b1
    } cfg_index_t;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned BITS_PER_HALF = 2;
    localparam int unsigned MODULUS       = 3329;
    localparam int unsigned POOL_BITS     = 16;
    localparam int unsigned NEED_BITS     = 2 * BITS_PER_HALF;
    localparam int unsigned MAX_DRAWS     = 1048576;
    localparam int unsigned DRAW_CNT_W    = $clog2(MAX_DRAWS);
    localparam int unsigned COUNT_W       = 4;
    // multiple of three that keeps the count difference non-negative
    localparam int unsigned RESIDUE_BIAS  = 9;

    localparam logic [WORD_W-1:0] MULT_RESET = 32'h0101_0101;
    localparam logic [WORD_W-1:0] INCR_RESET = 32'hb3b3_b3b3;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE   = SAMPLE_W'(1 % MODULUS);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MINUS = SAMPLE_W'(MODULUS - 1);
    localparam logic [SAMPLE_W:0]   MODULUS_EXT  = (SAMPLE_W + 1)'(MODULUS);

    // residue mod 3 of a value below 18, by compare and subtract
    function automatic logic [1:0] mod3_small(input logic [4:0] v);
        logic [4:0] r;
        r = v;
        if (r >= 5'd9) r = r - 5'd9;
        if (r >= 5'd6) r = r - 5'd6;
        if (r >= 5'd3) r = r - 5'd3;
        return r[1:0];
    endfunction

endpackage

@@ design/lcg_binomial_uniform_sampler.sv @@
// top level of the lcg binomial/uniform sampler
// one shared multiply/add draw unit under a small sequencer
// depends on lcg_bus_pkg
//
// Each input item carries an action. Reseed and restart are done in the idle state and
// give no result. A draw of the generator uses the shared unit: a 32x32 multiply (low
// half kept) in the multiply state, then the increment add and word forming in the add
// state. Uniform runs idle, multiply, add, deliver. Binomial skips multiply and add when
// the held word still has enough unused bits and runs them when it is refilled. Bounded
// uniform repeats multiply and add until a word falls below the modulus; after 2^20
// rejected draws the item ends with no result. The block accepts an item only while its
// sequencer is idle; a finished result waits in the output register, so the next item
// can be taken while it is not yet collected.
module lcg_binomial_uniform_sampler
    import lcg_bus_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            action,
    input  logic [WORD_W-1:0]     seed_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   sample
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_EXTRACT,
        ST_DELIVER
    } state_t;

    state_t                  state_reg;
    logic [2:0]              action_reg;
    logic [WORD_W-1:0]       mult_reg;
    logic [WORD_W-1:0]       incr_reg;
    logic [WORD_W-1:0]       gen_reg;
    logic [WORD_W-1:0]       prod_reg;
    logic [SAMPLE_W-1:0]     held_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [DRAW_CNT_W-1:0]   draw_cnt_reg;
    logic [SAMPLE_W-1:0]     res_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_W-1:0]     sample_reg;

    logic                    in_fire;
    logic                    refill;
    logic [WORD_W-1:0]       gen_next;
    logic [SAMPLE_W-1:0]     word;
    logic [WORD_W-1:0]       held_ext;
    logic [COUNT_W-1:0]      pos_cnt;
    logic [COUNT_W-1:0]      neg_cnt;
    logic [4:0]              bias_sum;
    logic [1:0]              residue;
    logic [SAMPLE_W-1:0]     binom_val;
    logic                    out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // pool runs dry when fewer than the needed bits remain
    assign refill = ({1'b0, pos_reg} + (POS_W + 1)'(NEED_BITS)) > (POS_W + 1)'(POOL_BITS);

    // second half of a draw: add increment and fold the state into a word
    assign gen_next = prod_reg + incr_reg;
    assign word     = {1'b0, gen_next[14:0]} ^ gen_next[31:16];

    // bit extraction from the held word, low bits first
    assign held_ext = {(WORD_W - SAMPLE_W)'(0), held_reg};
    always_comb
    begin
        pos_cnt = '0;
        neg_cnt = '0;
        for (int i = 0; i < BITS_PER_HALF; i++)
        begin
            pos_cnt = pos_cnt + COUNT_W'(held_ext[POS_W'(pos_reg + POS_W'(i))]);
            neg_cnt = neg_cnt
                + COUNT_W'(held_ext[POS_W'(pos_reg + POS_W'(BITS_PER_HALF + i))]);
        end
    end

    assign bias_sum = 5'(RESIDUE_BIAS) + 5'(pos_cnt) - 5'(neg_cnt);
    assign residue  = mod3_small(bias_sum);

    always_comb
    begin
        case (residue)
            2'd0:    binom_val = '0;
            2'd1:    binom_val = SAMPLE_ONE;
            default: binom_val = SAMPLE_MINUS;
        endcase
    end

    // sequencer, generator state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            action_reg    <= ACT_RESEED;
            mult_reg      <= MULT_RESET;
            incr_reg      <= INCR_RESET;
            gen_reg       <= '0;
            prod_reg      <= '0;
            held_reg      <= '0;
            pos_reg       <= POS_W'(POOL_BITS);
            draw_cnt_reg  <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MULTIPLIER: mult_reg <= cfg_data;
                    CFG_INCREMENT:  incr_reg <= cfg_data;
                    default:        mult_reg <= mult_reg;
                endcase
            end

            // collected item clears valid unless the deliver step refills it
            if (out_valid_reg && out_ready && (state_reg != ST_DELIVER))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        action_reg   <= action;
                        draw_cnt_reg <= '0;
                        unique case (action) inside
                            ACT_RESEED:
                                gen_reg <= seed_value;
                            ACT_RESTART:
                                pos_reg <= POS_W'(POOL_BITS);
                            ACT_UNIFORM, ACT_BOUNDED:
                                state_reg <= ST_MUL;
                            ACT_BINOMIAL:
                                state_reg <= refill ? ST_MUL : ST_EXTRACT;
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= mult_reg * gen_reg;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    gen_reg <= gen_next;
                    if (action_reg == ACT_BINOMIAL)
                    begin
                        held_reg  <= word;
                        pos_reg   <= '0;
                        state_reg <= ST_EXTRACT;
                    end
                    else if (action_reg == ACT_UNIFORM)
                    begin
                        res_reg   <= word;
                        state_reg <= ST_DELIVER;
                    end
                    else if ({1'b0, word} < MODULUS_EXT)
                    begin
                        res_reg   <= word;
                        state_reg <= ST_DELIVER;
                    end
                    else if (draw_cnt_reg == DRAW_CNT_W'(MAX_DRAWS - 1))
                    begin
                        // redraw limit reached, item ends with no result
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        draw_cnt_reg <= draw_cnt_reg + 1'b1;
                        state_reg    <= ST_MUL;
                    end
                end
                ST_EXTRACT:
                begin
                    res_reg   <= binom_val;
                    pos_reg   <= pos_reg + POS_W'(NEED_BITS);
                    state_reg <= ST_DELIVER;
                end
                ST_DELIVER:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sample_reg    <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // pool position never runs past the end of the held word
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(POOL_BITS))
        else $error("bit position beyond pool");

    // extraction only with enough unused bits
    a_extract_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXTRACT |-> !refill)
        else $error("extraction from an exhausted pool");

    // binomial results are 0, 1 or modulus minus one
    a_binom_value: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && action_reg == ACT_BINOMIAL) |->
        (res_reg == '0 || res_reg == SAMPLE_ONE || res_reg == SAMPLE_MINUS))
        else $error("binomial result out of set");

    // bounded results are below the modulus
    a_bounded_value: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && action_reg == ACT_BOUNDED) |->
        ({1'b0, res_reg} < MODULUS_EXT))
        else $error("bounded result not below modulus");

    // a uniform item starts a draw in the next cycle
    a_uniform_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == ACT_UNIFORM) |=> state_reg == ST_MUL)
        else $error("uniform item did not start a draw");

endmodule

@@ verif/tb_lcg_binomial_uniform_sampler.sv @@
// testbench for lcg_binomial_uniform_sampler: directed table, then random phases
// checks every sample against a cycle-free predictor of the generator and bit pool
// depends on lcg_bus_pkg and the sampler rtl
module tb_lcg_binomial_uniform_sampler;
    import lcg_bus_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int BOUNDED_CAP      = 1024;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 80;
    localparam int LONG_HOLD_AFTER  = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RESIDUE_OFFSET   = 3 * 64;

    localparam logic [2:0] FIRST_UNUSED_ACT = 3'd5;
    localparam logic [2:0] LAST_UNUSED_ACT  = 3'd7;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        logic                is_write;
        logic                reg_index;
        logic [WORD_W-1:0]   reg_value;
        logic [2:0]          act;
        logic [WORD_W-1:0]   seed;
        logic                has_fixed;
        logic [SAMPLE_W-1:0] fixed_sample;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write;
    logic                cfg_index;
    logic [WORD_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          action;
    logic [WORD_W-1:0]   seed_value;
    logic                out_valid;
    logic                out_ready;
    logic [SAMPLE_W-1:0] sample;

    // predictor state and configuration
    logic [WORD_W-1:0]   model_mult;
    logic [WORD_W-1:0]   model_incr;
    logic [WORD_W-1:0]   model_state;
    logic [SAMPLE_W-1:0] model_held;
    logic [POS_W-1:0]    model_pos;

    logic [SAMPLE_W-1:0] pending_samples[$];
    stim_row_t           directed_rows[$];
    stim_row_t           row;
    logic [SAMPLE_W-1:0] head_sample;

    int  error_count    = 0;
    int  results_seen   = 0;
    int  items_sent     = 0;
    int  reg_writes     = 0;
    int  quiet_cycles   = 0;
    int  phase_items;
    int  sink_gap;
    bit  long_hold_done = 1'b0;
    bit  gapless;
    logic [2:0]        rand_act;
    logic [WORD_W-1:0] rand_seed;
    logic [WORD_W-1:0] phase_mult;
    logic [WORD_W-1:0] phase_incr;
    int                pick;

    lcg_binomial_uniform_sampler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one generator step: new state, 16-bit word from low 15 xor high 16 bits
    function automatic logic [SAMPLE_W-1:0] lcg_draw();
        model_state = model_mult * model_state + model_incr;
        return {1'b0, model_state[14:0]} ^ model_state[31:16];
    endfunction

    // centered binomial from the held word, refilled when too few bits remain
    function automatic logic [SAMPLE_W-1:0] binomial_coeff();
        int          sum;
        int          residue;
        logic [31:0] pool;
        if (int'(model_pos) + NEED_BITS > POOL_BITS)
        begin
            model_held = lcg_draw();
            model_pos  = '0;
        end
        pool = {16'd0, model_held};
        sum  = 0;
        for (int i = 0; i < BITS_PER_HALF; i++)
        begin
            sum += int'(pool[(int'(model_pos) + i) % 32]);
            sum -= int'(pool[(int'(model_pos) + BITS_PER_HALF + i) % 32]);
        end
        model_pos = model_pos + POS_W'(NEED_BITS);
        residue   = (sum + RESIDUE_OFFSET) % 3;
        case (residue)
            0:       return '0;
            1:       return SAMPLE_ONE;
            default: return SAMPLE_MINUS;
        endcase
    endfunction

    // apply one item to the predictor; overrun marks a bounded draw past the cap
    task automatic predict_sample(input logic [2:0] act_in, input logic [WORD_W-1:0] seed_in,
                                  output bit produced, output bit overrun,
                                  output logic [SAMPLE_W-1:0] value);
        produced = 1'b0;
        overrun  = 1'b0;
        value    = '0;
        case (act_in)
            ACT_RESEED:   model_state = seed_in;
            ACT_UNIFORM:
            begin
                value    = lcg_draw();
                produced = 1'b1;
            end
            ACT_BINOMIAL:
            begin
                value    = binomial_coeff();
                produced = 1'b1;
            end
            ACT_BOUNDED:
            begin
                overrun = 1'b1;
                for (int n = 0; n < BOUNDED_CAP && overrun; n++)
                begin
                    value = lcg_draw();
                    if (value < MODULUS)
                    begin
                        produced = 1'b1;
                        overrun  = 1'b0;
                    end
                end
            end
            ACT_RESTART:  model_pos = POS_W'(POOL_BITS);
            default:      ;
        endcase
    endtask

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // table builders
    task automatic add_write(input cfg_index_t idx, input logic [WORD_W-1:0] value);
        stim_row_t r;
        r           = '0;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        directed_rows.push_back(r);
    endtask

    task automatic add_item(input logic [2:0] act_in, input logic [WORD_W-1:0] seed_in,
                            input logic has_fixed, input logic [SAMPLE_W-1:0] fixed);
        stim_row_t r;
        r              = '0;
        r.act          = act_in;
        r.seed         = seed_in;
        r.has_fixed    = has_fixed;
        r.fixed_sample = fixed;
        directed_rows.push_back(r);
    endtask

    // offer one item and hold it until accepted; bounded draws are kept short
    task automatic offer_item(input logic [2:0] act_in, input logic [WORD_W-1:0] seed_in,
                              input logic use_fixed, input logic [SAMPLE_W-1:0] fixed);
        bit                  produced;
        bit                  overrun;
        logic [SAMPLE_W-1:0] value;
        logic [WORD_W-1:0]   saved_state;
        logic [2:0]          act_now;
        act_now     = act_in;
        saved_state = model_state;
        predict_sample(act_now, seed_in, produced, overrun, value);
        if (overrun)
        begin
            model_state = saved_state;
            act_now     = ACT_UNIFORM;
            predict_sample(act_now, seed_in, produced, overrun, value);
        end
        if (produced)
            pending_samples.push_back(use_fixed ? fixed : value);
        in_valid   <= 1'b1;
        action     <= act_now;
        seed_value <= seed_in;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // sender gap after an item
    task automatic sender_gap(input bit no_gaps);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // wait for every expected sample, then let the sequencer settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input cfg_index_t idx, input logic [WORD_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_MULTIPLIER)
            model_mult = value;
        else
            model_incr = value;
        reg_writes++;
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_samples.size() == 0)
                begin
                    error_count++;
                    $error("unexpected result: sample %0d", sample);
                end
                else
                begin
                    head_sample = pending_samples.pop_front();
                    if (sample !== head_sample)
                    begin
                        error_count++;
                        $error("sample mismatch: expected %0d, actual %0d", head_sample, sample);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d samples outstanding",
                         quiet_cycles, pending_samples.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off to back up the input side
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            sink_gap = pick_gap();
            if (sink_gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (sink_gap) @(posedge clk);
            end
        end
    end

    // sender: reset, directed table, random phases, verdict
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= ACT_RESEED;
        seed_value <= '0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_MULTIPLIER;
        cfg_data   <= '0;

        model_mult  = MULT_RESET;
        model_incr  = INCR_RESET;
        model_state = '0;
        model_held  = '0;
        model_pos   = POS_W'(POOL_BITS);

        // from reset state 0 the first word is the increment folded
        add_item(ACT_UNIFORM, 32'h0, 1'b1, 16'h8000);
        // five binomials: the first refills, the first four use up the held word, the fifth refills
        repeat (5) add_item(ACT_BINOMIAL, 32'h0, 1'b0, '0);
        add_item(ACT_RESTART, 32'hffff_ffff, 1'b0, '0);
        add_item(ACT_BINOMIAL, 32'h0, 1'b0, '0);
        add_item(ACT_BOUNDED, 32'h0, 1'b0, '0);
        add_item(ACT_RESEED, 32'hffff_ffff, 1'b0, '0);
        add_item(ACT_UNIFORM, 32'h0, 1'b0, '0);
        // unused codes leave everything alone
        add_item(FIRST_UNUSED_ACT, 32'hffff_ffff, 1'b0, '0);
        add_item(FIRST_UNUSED_ACT + 3'd1, 32'hffff_ffff, 1'b0, '0);
        add_item(LAST_UNUSED_ACT, 32'hffff_ffff, 1'b0, '0);
        add_item(ACT_UNIFORM, 32'h0, 1'b0, '0);
        // zero multiplier and increment: every word is zero
        add_write(CFG_MULTIPLIER, 32'h0);
        add_write(CFG_INCREMENT, 32'h0);
        add_item(ACT_RESEED, 32'h1234_5678, 1'b0, '0);
        add_item(ACT_UNIFORM, 32'h0, 1'b1, 16'h0);
        add_item(ACT_BOUNDED, 32'h0, 1'b1, 16'h0);
        // held word 4: one negative bit, maps to modulus minus one
        add_write(CFG_INCREMENT, 32'h4);
        add_item(ACT_RESTART, 32'h0, 1'b0, '0);
        add_item(ACT_BINOMIAL, 32'h0, 1'b1, SAMPLE_MINUS);
        add_item(ACT_BINOMIAL, 32'h0, 1'b1, 16'h0);
        // held word 3: sum of two wraps to minus one
        add_write(CFG_INCREMENT, 32'h3);
        add_item(ACT_RESTART, 32'h0, 1'b0, '0);
        add_item(ACT_BINOMIAL, 32'h0, 1'b1, SAMPLE_MINUS);
        // held word 12: sum of minus two wraps to one
        add_write(CFG_INCREMENT, 32'hc);
        add_item(ACT_RESTART, 32'h0, 1'b0, '0);
        add_item(ACT_BINOMIAL, 32'h0, 1'b1, SAMPLE_ONE);
        // all-ones registers: state alternates between zero and all ones
        add_write(CFG_MULTIPLIER, 32'hffff_ffff);
        add_write(CFG_INCREMENT, 32'hffff_ffff);
        add_item(ACT_RESEED, 32'hffff_ffff, 1'b0, '0);
        add_item(ACT_UNIFORM, 32'h0, 1'b1, 16'h0);
        add_item(ACT_UNIFORM, 32'h0, 1'b1, 16'h8000);
        add_item(ACT_BOUNDED, 32'h0, 1'b1, 16'h0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.is_write)
            begin
                drain();
                write_reg(cfg_index_t'(row.reg_index), row.reg_value);
            end
            else
            begin
                offer_item(row.act, row.seed, row.has_fixed, row.fixed_sample);
                sender_gap(1'b0);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    phase_mult = MULT_RESET;
                    phase_incr = INCR_RESET;
                end
                1:
                begin
                    phase_mult = 32'hffff_ffff;
                    phase_incr = 32'h0;
                end
                2:
                begin
                    phase_mult = 32'h0;
                    phase_incr = $urandom;
                end
                3:
                begin
                    phase_mult = $urandom;
                    phase_incr = 32'hffff_ffff;
                end
                default:
                begin
                    phase_mult = $urandom | 32'h1;
                    phase_incr = $urandom;
                end
            endcase
            drain();
            write_reg(CFG_MULTIPLIER, phase_mult);
            write_reg(CFG_INCREMENT, phase_incr);
            gapless     = (phase % 3 == 1);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    rand_act = ACT_RESEED;
                else if (pick < 35)
                    rand_act = ACT_UNIFORM;
                else if (pick < 70)
                    rand_act = ACT_BINOMIAL;
                else if (pick < 85)
                    rand_act = ACT_BOUNDED;
                else if (pick < 93)
                    rand_act = ACT_RESTART;
                else
                    rand_act = 3'($urandom_range(FIRST_UNUSED_ACT, LAST_UNUSED_ACT));
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    rand_seed = '0;
                else if (pick < 10)
                    rand_seed = '1;
                else
                    rand_seed = $urandom;
                offer_item(rand_act, rand_seed, 1'b0, '0);
                if (rand_act <= ACT_RESTART)
                    phase_items++;
                sender_gap(gapless);
            end
        end

        drain();
        $display("%0d items sent, %0d samples checked, %0d register writes, %0d random phases",
                 items_sent, results_seen, reg_writes, NUM_PHASES);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/lcg_bus_pkg.sv
design/lcg_binomial_uniform_sampler.sv
verif/tb_lcg_binomial_uniform_sampler.sv
